// ----- sv/hufc_pkg.sv -----
// Shared types and constants of the Huffman cost block.
package hufc_pkg;

  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int WEIGHT_IN_W     = 16;
  localparam int COST_W          = 48;
  localparam int COUNT_OUT_W     = 11;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UP_ROOT,
    OP_UP_READ,
    OP_UP_CMP,
    OP_POP_READ,
    OP_POP_LOAD,
    OP_SIFT,
    OP_TOP_READ,
    OP_TOP_LOAD,
    OP_EMIT
  } hufc_op_e;

  typedef struct packed {
    hufc_op_e op;
    logic     replace;  // sift of a merge sum: add it to the cost when it settles
  } hufc_cmd_t;

  typedef struct packed {
    logic full;        // heap holds MAX_ITEMS entries
    logic in_last;     // last flag of the request on the input port
    logic last;        // last flag of the request being inserted
    logic i_zero;      // insert position is the root
    logic up_done;     // parent is not larger: insert settles here
    logic up_to_root;  // next insert position is the root
    logic one_left;    // at most one entry in the heap
    logic sift_done;   // sifted value settles at the current position
    logic out_free;    // output register can take a result this cycle
  } hufc_st_t;

endpackage

// ----- sv/hufc_ctrl.sv -----
// Sequencer of the Huffman cost block: insert, merge and emit phases.
module hufc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output hufc_pkg::hufc_cmd_t cmd_o,
  input  hufc_pkg::hufc_st_t  st_i
);
  import hufc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP     = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_MRG    = 4'd3;
  localparam logic [3:0] S_POP_LD = 4'd4;
  localparam logic [3:0] S_SIFT   = 4'd5;
  localparam logic [3:0] S_TOP_RD = 4'd6;
  localparam logic [3:0] S_TOP_LD = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       replace_q, replace_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    replace_d     = replace_q;
    cmd_o.op      = OP_NONE;
    cmd_o.replace = replace_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (!st_i.full) begin
            state_d = S_UP;
          end else if (st_i.in_last) begin
            state_d = S_MRG;
          end
        end
      end
      S_UP: begin
        if (st_i.i_zero) begin
          cmd_o.op = OP_UP_ROOT;
          state_d  = st_i.last ? S_MRG : S_IDLE;
        end else begin
          cmd_o.op = OP_UP_READ;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd_o.op = OP_UP_CMP;
        if (st_i.up_done) begin
          state_d = st_i.last ? S_MRG : S_IDLE;
        end else if (st_i.up_to_root) begin
          state_d = S_UP;
        end
      end
      S_MRG: begin
        if (st_i.one_left) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.op  = OP_POP_READ;
          replace_d = 1'b0;
          state_d   = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cmd_o.op = OP_POP_LOAD;
        state_d  = S_SIFT;
      end
      S_SIFT: begin
        cmd_o.op = OP_SIFT;
        if (st_i.sift_done) begin
          state_d = replace_q ? S_MRG : S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        cmd_o.op = OP_TOP_READ;
        state_d  = S_TOP_LD;
      end
      S_TOP_LD: begin
        cmd_o.op  = OP_TOP_LOAD;
        replace_d = 1'b1;
        state_d   = S_SIFT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      replace_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      replace_q <= replace_d;
    end
  end

endmodule

// ----- sv/hufc_dp.sv -----
// Datapath of the Huffman cost block: heap memory, counters, cost and output register.
module hufc_dp #(
  parameter int MAX_ITEMS   = hufc_pkg::MAX_ITEMS_DEF,
  parameter int WEIGHT_BITS = hufc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hufc_pkg::WEIGHT_IN_W-1:0]  weight_i,
  input  logic                              last_i,
  input  logic                              out_stall_i,
  input  hufc_pkg::hufc_cmd_t               cmd_i,
  output hufc_pkg::hufc_st_t                st_o,
  output logic                              out_valid_o,
  output logic [hufc_pkg::COST_W-1:0]       total_cost_o,
  output logic [hufc_pkg::COUNT_OUT_W-1:0]  item_count_o,
  output logic                              overflow_o
);
  import hufc_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = CW + 1;
  localparam int EW = WEIGHT_BITS + AW;

  logic [EW-1:0] mem [MAX_ITEMS];
  logic [EW-1:0] rd0_q, rd1_q, wd;
  logic [AW-1:0] ra0, ra1, wa;
  logic          we;

  logic [CW-1:0]          count_q, count_d, loaded_q, loaded_d;
  logic                   dropped_q, dropped_d;
  logic [COST_W-1:0]      cost_q, cost_d;
  logic                   out_valid_q, out_valid_d;
  logic [COST_W-1:0]      out_cost_q, out_cost_d;
  logic [COUNT_OUT_W-1:0] out_count_q, out_count_d;
  logic                   out_ovf_q, out_ovf_d;
  logic [EW-1:0]          v_q, v_d, a_q, a_d;
  logic [AW-1:0]          i_q, i_d;
  logic                   last_q, last_d;

  logic [AW-1:0] parent, grandparent, c_idx;
  logic [IW-1:0] c1, c2, gc1, gc2;
  logic          c1_ok, c2_ok, pick2, sift_done;
  logic [EW-1:0] cval;

  assign parent      = AW'((i_q - AW'(1)) >> 1);
  assign grandparent = AW'((parent - AW'(1)) >> 1);
  assign c1          = IW'({i_q, 1'b1});
  assign c2          = c1 + IW'(1);
  assign c1_ok       = c1 < IW'(count_q);
  assign c2_ok       = c2 < IW'(count_q);
  assign pick2       = c2_ok && (rd1_q < rd0_q);
  assign cval        = pick2 ? rd1_q : rd0_q;
  assign c_idx       = pick2 ? AW'(c2) : AW'(c1);
  assign gc1         = IW'({c_idx, 1'b1});
  assign gc2         = gc1 + IW'(1);
  assign sift_done   = !c1_ok || (cval >= v_q);

  always_comb begin
    st_o.full       = (count_q == CW'(MAX_ITEMS));
    st_o.in_last    = last_i;
    st_o.last       = last_q;
    st_o.i_zero     = (i_q == '0);
    st_o.up_done    = (rd0_q <= v_q);
    st_o.up_to_root = (parent == '0);
    st_o.one_left   = (count_q <= CW'(1));
    st_o.sift_done  = sift_done;
    st_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    we          = 1'b0;
    wa          = i_q;
    wd          = v_q;
    ra0         = '0;
    ra1         = '0;
    count_d     = count_q;
    loaded_d    = loaded_q;
    dropped_d   = dropped_q;
    cost_d      = cost_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_cost_d  = out_cost_q;
    out_count_d = out_count_q;
    out_ovf_d   = out_ovf_q;
    v_d         = v_q;
    a_d         = a_q;
    i_d         = i_q;
    last_d      = last_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_ACCEPT: begin
        last_d = last_i;
        if (!st_o.full) begin
          v_d      = EW'(weight_i[WEIGHT_BITS-1:0]);
          i_d      = count_q[AW-1:0];
          count_d  = count_q + CW'(1);
          loaded_d = loaded_q + CW'(1);
        end else begin
          dropped_d = 1'b1;
        end
      end
      OP_UP_ROOT: begin
        we = 1'b1;
        wa = '0;
      end
      OP_UP_READ: begin
        ra0 = parent;
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (!st_o.up_done) begin
          // Move the parent down, climb one level.
          wd  = rd0_q;
          i_d = parent;
          ra0 = grandparent;
        end
      end
      OP_POP_READ: begin
        ra0     = '0;
        ra1     = AW'(count_q - CW'(1));
        count_d = count_q - CW'(1);
      end
      OP_POP_LOAD: begin
        a_d = rd0_q;
        v_d = rd1_q;
        i_d = '0;
        ra0 = AW'(1);
        ra1 = AW'(2);
      end
      OP_SIFT: begin
        we = 1'b1;
        if (sift_done) begin
          if (cmd_i.replace) begin
            cost_d = cost_q + COST_W'(v_q);
          end
        end else begin
          // Move the smaller child up, descend one level.
          wd  = cval;
          i_d = c_idx;
          ra0 = AW'(gc1);
          ra1 = AW'(gc2);
        end
      end
      OP_TOP_READ: begin
        ra0 = '0;
      end
      OP_TOP_LOAD: begin
        v_d = a_q + rd0_q;
        i_d = '0;
        ra0 = AW'(1);
        ra1 = AW'(2);
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        out_cost_d  = cost_q;
        out_count_d = COUNT_OUT_W'(loaded_q);
        out_ovf_d   = dropped_q;
        count_d     = '0;
        loaded_d    = '0;
        dropped_d   = 1'b0;
        cost_d      = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      loaded_q    <= '0;
      dropped_q   <= 1'b0;
      cost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      loaded_q    <= loaded_d;
      dropped_q   <= dropped_d;
      cost_q      <= cost_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cost_q  <= out_cost_d;
    out_count_q <= out_count_d;
    out_ovf_q   <= out_ovf_d;
    v_q         <= v_d;
    a_q         <= a_d;
    i_q         <= i_d;
    last_q      <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign total_cost_o = out_cost_q;
  assign item_count_o = out_count_q;
  assign overflow_o   = out_ovf_q;

endmodule

// ----- sv/huffman_total_cost.sv -----
// Top level of the Huffman cost block: sequencer plus heap datapath.
//
// Usage: send a run of weights on the input channel (in_valid_i, in_stall_o,
// weight_i, last_i), one request per weight, last_i high on the final one.
// Each weight goes into a binary min-heap held in one memory with one write
// and two registered read ports. After the final weight the block merges the
// two smallest entries again and again, adds each merge sum to a 48-bit cost,
// and then presents one result on the output channel (out_valid_o,
// out_stall_i, total_cost_o, item_count_o, overflow_o). Weights that arrive
// while the heap holds MAX_ITEMS entries are dropped and set overflow_o.
// Steps: an insert writes the weight straight to the root when it lands there;
// else it reads the parent and compares, moving the parent down and climbing
// a level until it settles, a sift-up over the single memory. Each merge pops
// the root and the last entry, sifts the last entry down from the root, reads
// the new root, replaces it with the merge sum and sifts that down; when one
// entry is left the block emits the result.
// The input is stalled during all of this; one run is processed at a time.
// A result held by out_stall_i stays in the output register; the block
// waits in its emit step until the register is free. Reset clears the
// counters, cost and output valid; heap memory needs no clearing pass.
module huffman_total_cost #(
  parameter int MAX_ITEMS   = hufc_pkg::MAX_ITEMS_DEF,
  parameter int WEIGHT_BITS = hufc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hufc_pkg::WEIGHT_IN_W-1:0]  weight_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hufc_pkg::COST_W-1:0]       total_cost_o,
  output logic [hufc_pkg::COUNT_OUT_W-1:0]  item_count_o,
  output logic                              overflow_o
);
  import hufc_pkg::*;

  hufc_cmd_t cmd;
  hufc_st_t  st;

  // Sequencer: decides one datapath operation per cycle.
  hufc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  // Heap memory, index arithmetic, comparisons and the result register.
  hufc_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .weight_i     (weight_i),
    .last_i       (last_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_valid_o  (out_valid_o),
    .total_cost_o (total_cost_o),
    .item_count_o (item_count_o),
    .overflow_o   (overflow_o)
  );

  // A taken request always turns into the accept operation.
  a_accept_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (cmd.op == OP_ACCEPT))
    else $error("input request taken without insert operation");

  // Never overwrite a result that is still waiting at the output.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EMIT) |-> st.out_free)
    else $error("result emitted over an undelivered one");

  // Merges only start with at least two entries in the heap.
  a_pop_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_POP_READ) |-> !st.one_left)
    else $error("merge started with fewer than two entries");

  // An emitted result shows up as valid in the next cycle.
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EMIT) |=> out_valid_o)
    else $error("emitted result not presented");

endmodule
